FILE: sv/teletext_epg_packet_filter_unit_assert.svh
// ----------------------------------------------------------------------------
// teletext epg packet filter assertion macros
// concurrent property helpers, sampled on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TELETEXT_EPG_PACKET_FILTER_UNIT_ASSERT_SVH
`define TELETEXT_EPG_PACKET_FILTER_UNIT_ASSERT_SVH

// same-cycle implication
`define TEPF_ASSERT_NOW(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define TEPF_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: sv/tepf_pkg.sv
// ----------------------------------------------------------------------------
// tepf_pkg
// shared types and constants of the teletext epg packet filter
// ----------------------------------------------------------------------------
package tepf_pkg;

   // packet classes
   localparam logic [2:0] KIND_IGNORED    = 3'd0;
   localparam logic [2:0] KIND_EPG_HEADER = 3'd1;
   localparam logic [2:0] KIND_EPG_DATA   = 3'd2;
   localparam logic [2:0] KIND_INVENTORY  = 3'd3;
   localparam logic [2:0] KIND_CNI        = 3'd4;

   // teletext constants
   localparam logic [7:0] INVENTORY_PAGE_BYTE = 8'hFD;
   localparam logic [4:0] FIRST_NON_DATA_ROW  = 5'd26;
   localparam logic [4:0] CNI_ROW             = 5'd30;
   localparam logic [4:0] HEADER_ROW          = 5'd0;
   localparam logic [2:0] CNI_MAGAZINE        = 3'd0;

   // register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACQ_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EPG_PAGE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCAN_MODE  = 2'd2;

   typedef struct packed {
      logic [10:0] page_number;
      logic [15:0] subcode;
      logic [4:0]  packet_number;
   } tepf_req_type;

   typedef struct packed {
      logic [2:0]  packet_kind;
      logic        used_by_epg;
      logic        to_scan;
      logic [15:0] subcode_out;
      logic [31:0] total_packets;
      logic [31:0] epg_packets;
      logic [31:0] epg_pages;
   } tepf_rsp_type;

endpackage

FILE: sv/tepf_core.sv
// ----------------------------------------------------------------------------
// tepf_core
// control registers, acquisition state and packet classification
// ----------------------------------------------------------------------------
module tepf_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [tepf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tepf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               step_valid,
   input  tepf_pkg::tepf_req_type             step_req,
   output tepf_pkg::tepf_rsp_type             step_rsp
);
   import tepf_pkg::*;

   logic        acq_enable_ff;
   logic [10:0] epg_page_ff;
   logic        scan_mode_ff;

   logic        page_open_ff,  page_open_in;
   logic [7:0]  inv_mags_ff,   inv_mags_in;
   logic [31:0] cnt_total_ff,  cnt_total_in;
   logic [31:0] cnt_epkt_ff,   cnt_epkt_in;
   logic [31:0] cnt_epage_ff,  cnt_epage_in;

   logic [2:0]  mag;
   logic [7:0]  mag_bit;
   logic        same_mag;
   logic [2:0]  kind;

   // field decode
   assign mag      = step_req.page_number[10:8];
   assign mag_bit  = 8'(1) << mag;
   assign same_mag = (mag == epg_page_ff[10:8]);

   // classification and next state
   always_comb begin
      page_open_in = page_open_ff;
      inv_mags_in  = inv_mags_ff;
      cnt_total_in = cnt_total_ff;
      cnt_epkt_in  = cnt_epkt_ff;
      cnt_epage_in = cnt_epage_ff;
      kind         = KIND_IGNORED;
      if (acq_enable_ff) begin
         cnt_total_in = cnt_total_ff + 32'd1;
         if (step_req.packet_number == HEADER_ROW) begin
            if (step_req.page_number == epg_page_ff) begin
               page_open_in = 1'b1;
               cnt_epkt_in  = cnt_epkt_ff + 32'd1;
               cnt_epage_in = cnt_epage_ff + 32'd1;
               kind         = KIND_EPG_HEADER;
            end else begin
               if (same_mag) begin
                  page_open_in = 1'b0;
               end
               if (step_req.page_number[7:0] == INVENTORY_PAGE_BYTE) begin
                  inv_mags_in = inv_mags_ff | mag_bit;
               end else begin
                  inv_mags_in = inv_mags_ff & ~mag_bit;
               end
            end
         end else if (page_open_ff && same_mag &&
                      step_req.packet_number < FIRST_NON_DATA_ROW) begin
            cnt_epkt_in = cnt_epkt_ff + 32'd1;
            kind        = KIND_EPG_DATA;
         end else if ((inv_mags_ff & mag_bit) != 8'd0) begin
            kind = KIND_INVENTORY;
         end else if (scan_mode_ff && step_req.packet_number == CNI_ROW &&
                      mag == CNI_MAGAZINE) begin
            kind = KIND_CNI;
         end
      end
   end

   // result assembly
   always_comb begin
      step_rsp.packet_kind   = kind;
      step_rsp.used_by_epg   = (kind == KIND_EPG_HEADER) || (kind == KIND_EPG_DATA);
      step_rsp.to_scan       = acq_enable_ff & scan_mode_ff;
      step_rsp.subcode_out   = step_req.subcode;
      step_rsp.total_packets = cnt_total_in;
      step_rsp.epg_packets   = cnt_epkt_in;
      step_rsp.epg_pages     = cnt_epage_in;
   end

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         acq_enable_ff <= 1'b0;
         epg_page_ff   <= 11'd0;
         scan_mode_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACQ_ENABLE: acq_enable_ff <= csr_wdata[0];
            CSR_EPG_PAGE:   epg_page_ff   <= csr_wdata[10:0];
            CSR_SCAN_MODE:  scan_mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // acquisition state, updated once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         page_open_ff <= 1'b0;
         inv_mags_ff  <= 8'd0;
         cnt_total_ff <= 32'd0;
         cnt_epkt_ff  <= 32'd0;
         cnt_epage_ff <= 32'd0;
      end else if (step_valid) begin
         page_open_ff <= page_open_in;
         inv_mags_ff  <= inv_mags_in;
         cnt_total_ff <= cnt_total_in;
         cnt_epkt_ff  <= cnt_epkt_in;
         cnt_epage_ff <= cnt_epage_in;
      end
   end

   `include "teletext_epg_packet_filter_unit_assert.svh"

   `TEPF_ASSERT_NEXT(a_disabled_holds_counts, step_valid && !acq_enable_ff && !csr_we, $stable(cnt_total_ff) && $stable(cnt_epkt_ff) && $stable(cnt_epage_ff), "counters moved while disabled")
   `TEPF_ASSERT_NEXT(a_header_opens_page, step_valid && kind == KIND_EPG_HEADER, page_open_ff && cnt_epage_ff == 32'($past(cnt_epage_ff) + 32'd1), "epg header did not open page")
   `TEPF_ASSERT_NEXT(a_idle_keeps_state, !step_valid, $stable(page_open_ff) && $stable(inv_mags_ff) && $stable(cnt_total_ff), "state changed without a request")

endmodule

FILE: sv/teletext_epg_packet_filter_unit.sv
// ----------------------------------------------------------------------------
// teletext_epg_packet_filter_unit
// classifies teletext packet descriptors for epg page acquisition
// ----------------------------------------------------------------------------
// usage:
//   req channel: page number, subcode and packet row of one teletext packet;
//   taken at a clock edge with req_valid high and req_stall low.
//   rsp channel: packet class, epg flag, scan flag, subcode and the three
//   wrapping counters after this packet; taken when rsp_valid and !rsp_stall.
//   csr port: write acq_enable, epg_page or scan_mode by index while idle;
//   writes take effect at once and clear nothing.
// path: a request taken into the input register passes through the
//   classification into the response register, which drives rsp.
// throughput: one request per cycle while rsp is not stalled; the input
//   register feeds a single classification pass into the response register.
// reset: synchronous; clears control registers, counters, page and inventory
//   state and both valid flags.
// stall: while the response waits, one more request is held in the input
//   register; req_stall rises only when both registers are full.
// ----------------------------------------------------------------------------
module teletext_epg_packet_filter_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tepf_pkg::tepf_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tepf_pkg::tepf_rsp_type             rsp_data,
   input  logic                               csr_we,
   input  logic [tepf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tepf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tepf_pkg::*;

   logic         in_valid_ff;
   tepf_req_type in_data_ff;
   logic         out_valid_ff;
   tepf_rsp_type out_data_ff;
   tepf_rsp_type step_rsp;
   logic         advance;

   // stage handoff
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   // classification and state
   tepf_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .step_valid (advance),
      .step_req   (in_data_ff),
      .step_rsp   (step_rsp)
   );

endmodule
